@@ hw/rtl/overwrite_ring_packet_buffer_macros.svh @@
// ----------------------------------------------------------------------------
// overwrite ring packet buffer assertion macros
// clocked on clk, disabled while rst is high
// ----------------------------------------------------------------------------
`ifndef OVERWRITE_RING_PACKET_BUFFER_MACROS_SVH
`define OVERWRITE_RING_PACKET_BUFFER_MACROS_SVH

// condition holds in the same cycle
`define ORPB_ASSERT_SAME(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("ring buffer port check failed");

// condition holds in the following cycle
`define ORPB_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("ring buffer port check failed");

`endif

@@ hw/rtl/orpb_pkg.sv @@
// ----------------------------------------------------------------------------
// orpb_pkg
// shared types and constants of the overwrite ring packet buffer
// ----------------------------------------------------------------------------
`default_nettype none

package orpb_pkg;

  // default sizes
  localparam int SLOTS_DEF         = 16;
  localparam int MAX_MSG_BYTES_DEF = 64;

  // configuration register
  localparam int           CFG_W     = 5;
  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  // result length field width
  localparam int LEN_W = 7;

  // command codes
  localparam logic CMD_PUT = 1'b0;
  localparam logic CMD_GET = 1'b1;

  // one input item
  typedef struct packed {
    logic       command;
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  // one result item
  typedef struct packed {
    logic [7:0]       out_byte;
    logic [LEN_W-1:0] msg_length;
    logic             end_of_message;
    logic             was_empty;
  } result_t;

  // controller to datapath commands
  typedef struct packed {
    logic do_put;
    logic emit_empty;
    logic load_len;
    logic rd_byte;
    logic pop;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic ring_empty;
    logic last_k;
  } dp_status_t;

endpackage

`default_nettype wire

@@ hw/rtl/orpb_ctrl.sv @@
// ----------------------------------------------------------------------------
// orpb_ctrl
// sequencer: takes commands, runs the length fetch and byte stream of a get
// ----------------------------------------------------------------------------
`default_nettype none

module orpb_ctrl (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  start,
  input  wire                  command,
  output logic                 busy,
  input  orpb_pkg::dp_status_t status,
  output orpb_pkg::dp_cmd_t    cmd
);
  import orpb_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_LEN    = 3'b010,
    ST_STREAM = 3'b100
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  // next state and datapath commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (command == CMD_PUT) begin
            cmd.do_put = 1'b1;
          end else if (status.ring_empty) begin
            cmd.emit_empty = 1'b1;
          end else begin
            state_next = ST_LEN;
          end
        end
      end
      ST_LEN: begin
        cmd.load_len = 1'b1;
        state_next   = ST_STREAM;
      end
      ST_STREAM: begin
        cmd.rd_byte = 1'b1;
        if (status.last_k) begin
          cmd.pop    = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/orpb_datapath.sv @@
// ----------------------------------------------------------------------------
// orpb_datapath
// ring pointers, message and length memories, result registers
// ----------------------------------------------------------------------------
`default_nettype none

module orpb_datapath #(
  parameter int SLOTS         = orpb_pkg::SLOTS_DEF,
  parameter int MAX_MSG_BYTES = orpb_pkg::MAX_MSG_BYTES_DEF
) (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        cfg_valid,
  input  wire [orpb_pkg::CFG_W-1:0]  cfg_data,
  input  orpb_pkg::item_t            item,
  input  orpb_pkg::dp_cmd_t          cmd,
  output orpb_pkg::dp_status_t       status,
  output logic                       result_valid,
  output orpb_pkg::result_t          result
);
  import orpb_pkg::*;

  localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW    = $clog2(SLOTS + 1);
  localparam int OW    = $clog2(MAX_MSG_BYTES + 1);
  localparam int DEPTH = SLOTS * MAX_MSG_BYTES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // memories
  logic [7:0]    msg_mem [DEPTH];
  logic [OW-1:0] len_mem [SLOTS];

  // ring state
  logic [CFG_W-1:0] slots_cfg;
  logic [SW-1:0]    oldest;
  logic [CW-1:0]    count;
  logic             open_msg;
  logic [OW-1:0]    wr_off;

  // get state
  logic [OW-1:0] len_rd;
  logic [OW-1:0] len_q;
  logic [OW-1:0] len_eff;
  logic [OW-1:0] k;
  logic [7:0]    rd_byte;

  // result registers
  logic             emit_q;
  logic             eom_q;
  logic             empty_q;
  logic [LEN_W-1:0] len_out_q;

  // combinational helpers
  logic [CW-1:0] ring_n;
  logic [SW-1:0] oldest_inc;
  logic [SW-1:0] p_oldest;
  logic [CW-1:0] p_count;
  logic [OW-1:0] p_off;
  logic [OW-1:0] p_off_new;
  logic          p_store;
  logic [CW:0]   p_sum;
  logic [SW-1:0] p_slot;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;

  // effective ring length from the slot count register
  always_comb begin
    if (slots_cfg == '0) begin
      ring_n = CW'(1);
    end else if (32'(slots_cfg) > 32'(SLOTS)) begin
      ring_n = CW'(SLOTS);
    end else begin
      ring_n = CW'(slots_cfg);
    end
  end

  // oldest pointer advanced with wrap
  always_comb begin
    if ((CW'(oldest) + CW'(1)) >= ring_n) begin
      oldest_inc = '0;
    end else begin
      oldest_inc = oldest + SW'(1);
    end
  end

  // put: claim slot, drop oldest when full, locate write position
  always_comb begin
    p_oldest = oldest;
    p_count  = count;
    if (!open_msg && (count >= ring_n)) begin
      p_oldest = oldest_inc;
      p_count  = ring_n - CW'(1);
    end
    p_off     = open_msg ? wr_off : '0;
    p_store   = (p_off < OW'(MAX_MSG_BYTES));
    p_off_new = p_store ? (p_off + OW'(1)) : p_off;
    p_sum     = (CW + 1)'(p_oldest) + (CW + 1)'(p_count);
    if (p_sum >= (CW + 1)'(ring_n)) begin
      p_slot = SW'(p_sum - (CW + 1)'(ring_n));
    end else begin
      p_slot = SW'(p_sum);
    end
  end

  // memory addresses
  assign wr_addr = AW'((AW + 1)'(p_slot) * (AW + 1)'(MAX_MSG_BYTES) + (AW + 1)'(p_off));
  assign rd_addr = AW'((AW + 1)'(oldest) * (AW + 1)'(MAX_MSG_BYTES) + (AW + 1)'(k));

  // stored length bounded to the slot size
  assign len_eff = (len_rd > OW'(MAX_MSG_BYTES)) ? OW'(MAX_MSG_BYTES) : len_rd;

  // status back to the controller
  assign status.ring_empty = (count == '0);
  assign status.last_k     = ((OW + 1)'(k) + (OW + 1)'(1)) >= (OW + 1)'(len_q);

  // ring pointers and open message tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      slots_cfg <= CFG_RESET;
      oldest    <= '0;
      count     <= '0;
      open_msg  <= 1'b0;
      wr_off    <= '0;
    end else if (cfg_valid) begin
      slots_cfg <= cfg_data;
      oldest    <= '0;
      count     <= '0;
      open_msg  <= 1'b0;
      wr_off    <= '0;
    end else if (cmd.do_put) begin
      oldest <= p_oldest;
      if (item.last_byte) begin
        count    <= p_count + CW'(1);
        open_msg <= 1'b0;
        wr_off   <= '0;
      end else begin
        count    <= p_count;
        open_msg <= 1'b1;
        wr_off   <= p_off_new;
      end
    end else if (cmd.pop) begin
      oldest <= oldest_inc;
      count  <= count - CW'(1);
    end
  end

  // message byte memory
  always_ff @(posedge clk) begin
    if (cmd.do_put && p_store) begin
      msg_mem[wr_addr] <= item.data_byte;
    end
    if (cmd.rd_byte) begin
      rd_byte <= msg_mem[rd_addr];
    end
  end

  // length memory, read continuously at the oldest slot
  always_ff @(posedge clk) begin
    if (cmd.do_put && item.last_byte) begin
      len_mem[p_slot] <= p_off_new;
    end
    len_rd <= len_mem[oldest];
  end

  // byte counter of the get in progress
  always_ff @(posedge clk) begin
    if (cmd.load_len) begin
      len_q <= len_eff;
      k     <= '0;
    end else if (cmd.rd_byte) begin
      k <= k + OW'(1);
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      emit_q <= 1'b0;
    end else begin
      emit_q <= cmd.rd_byte || cmd.emit_empty;
    end
  end

  // result fields
  always_ff @(posedge clk) begin
    eom_q     <= cmd.emit_empty || (cmd.rd_byte && status.last_k);
    empty_q   <= cmd.emit_empty;
    len_out_q <= cmd.emit_empty ? '0 : LEN_W'(len_q);
  end

  assign result_valid          = emit_q;
  assign result.out_byte       = empty_q ? 8'h00 : rd_byte;
  assign result.msg_length     = len_out_q;
  assign result.end_of_message = eom_q;
  assign result.was_empty      = empty_q;

endmodule

`default_nettype wire

@@ hw/rtl/overwrite_ring_packet_buffer.sv @@
// ----------------------------------------------------------------------------
// overwrite_ring_packet_buffer
// ring of message slots that drops the oldest message when a put finds it full
// ----------------------------------------------------------------------------
// Usage
//   command channel: an item transfers on a rising edge with start high and
//   busy low. A put carries one message byte; last_byte closes the message.
//   A get returns the oldest stored message one byte per result.
//   results: result_valid marks each result for exactly one cycle; the
//   receiver cannot stall, so results must be taken as they come.
//   configuration: cfg_data transfers with cfg_valid and cfg_ready (always
//   high); writing the slot count empties the ring and drops an open message.
// Timing
//   put: no result, and busy stays low, so the next item can follow.
//   get on an empty ring: one result in the cycle after the transfer.
//   get of a message: busy while the sequencer passes through its length
//   state, which loads the registered length read, and its stream state,
//   which reads the byte memory one byte per cycle; each byte read is
//   registered and returned as one result, with no gap between bytes.
// Reset
//   rst is synchronous: the ring is empty, the slot count is sixteen, no
//   clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module overwrite_ring_packet_buffer #(
  parameter int SLOTS         = orpb_pkg::SLOTS_DEF,
  parameter int MAX_MSG_BYTES = orpb_pkg::MAX_MSG_BYTES_DEF
) (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        start,
  output logic                       busy,
  input  orpb_pkg::item_t            item,
  input  wire                        cfg_valid,
  output logic                       cfg_ready,
  input  wire [orpb_pkg::CFG_W-1:0]  cfg_data,
  output logic                       result_valid,
  output orpb_pkg::result_t          result
);
  import orpb_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       cfg_write;

  // configuration is always taken
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  // sequencer
  orpb_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (item.command),
    .busy    (busy),
    .status  (status),
    .cmd     (cmd)
  );

  // storage and pointers
  orpb_datapath #(
    .SLOTS         (SLOTS),
    .MAX_MSG_BYTES (MAX_MSG_BYTES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_write),
    .cfg_data     (cfg_data),
    .item         (item),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

`default_nettype wire

@@ hw/rtl/orpb_checker.sv @@
// ----------------------------------------------------------------------------
// orpb_checker
// port-level checks of the overwrite ring packet buffer, bound to the top
// ----------------------------------------------------------------------------
`default_nettype none

`include "overwrite_ring_packet_buffer_macros.svh"

module orpb_checker (
  input wire               clk,
  input wire               rst,
  input wire               start,
  input wire               busy,
  input orpb_pkg::item_t   item,
  input wire               result_valid,
  input orpb_pkg::result_t result
);
  import orpb_pkg::*;

  // empty ring result is a single closing result of length zero
  `ORPB_ASSERT_SAME(a_empty_form, result_valid && result.was_empty, result.end_of_message && (result.msg_length == '0) && (result.out_byte == 8'h00))

  // bytes of one message come in consecutive cycles
  `ORPB_ASSERT_NEXT(a_stream_gapless, result_valid && !result.end_of_message, result_valid && !result.was_empty)

  // a message byte short of the end appears while the get is still running
  `ORPB_ASSERT_SAME(a_busy_mid_stream, result_valid && !result.end_of_message, busy)

  // a get either starts streaming or answers empty at once
  `ORPB_ASSERT_NEXT(a_get_response, start && !busy && (item.command == CMD_GET), busy || (result_valid && result.was_empty))

endmodule

bind overwrite_ring_packet_buffer orpb_checker u_orpb_checker (.*);

`default_nettype wire

@@ tb/overwrite_ring_packet_buffer_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// overwrite_ring_packet_buffer_tb
// drives put and get commands and slot counts into the message ring, and
// mirrors every transfer in a behavioural ring to check each read-out byte
// ----------------------------------------------------------------------------

module overwrite_ring_packet_buffer_tb;
  import orpb_pkg::*;

  localparam int RING_DEPTH  = SLOTS_DEF;
  localparam int MSG_CAP     = MAX_MSG_BYTES_DEF;
  localparam int SETTLE      = 6;
  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_ITEMS = 14;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t         kind;
    item_t             cmd;
    logic [CFG_W-1:0]  slots;
    bit                typed;
    result_t           want;
  } script_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  item_t             cmd_item = '0;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CFG_W-1:0]  cfg_data = CFG_RESET;
  logic              result_valid;
  result_t           readout;

  // behavioural copy of the ring
  logic [7:0]        slot_bytes [RING_DEPTH][MSG_CAP];
  logic [LEN_W-1:0]  slot_len [RING_DEPTH];
  int unsigned       ring_size;
  int unsigned       head_slot;
  int unsigned       held_msgs;
  int unsigned       fill_offset;
  bit                msg_open;

  result_t           due_readout [$];
  result_t           step_readout [$];
  bit                typed_row = 1'b0;
  result_t           typed_want = '0;
  bit                idle_on = 1'b0;
  int unsigned       items_sent = 0;
  int unsigned       fail_count = 0;
  int unsigned       stall_cycles = 0;

  overwrite_ring_packet_buffer u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .item         (cmd_item),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .result       (readout)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // out-of-range slot counts fold to 1 or the full depth
  function automatic int unsigned ring_size_of(input logic [CFG_W-1:0] v);
    if (v == '0) return 1;
    if (v > RING_DEPTH) return RING_DEPTH;
    return v;
  endfunction

  function automatic void empty_ring(input logic [CFG_W-1:0] v);
    ring_size   = ring_size_of(v);
    head_slot   = 0;
    held_msgs   = 0;
    fill_offset = 0;
    msg_open    = 1'b0;
  endfunction

  // next state of the ring for one command, read-out bytes into step_readout
  function automatic void ring_track(input item_t it);
    int unsigned slot;
    int unsigned len;
    result_t     r;
    step_readout.delete();
    if (it.command == CMD_PUT) begin
      // first byte claims a slot, dropping the oldest message when full
      if (!msg_open) begin
        if (held_msgs >= ring_size) begin
          head_slot = (head_slot + 1) % ring_size;
          held_msgs = ring_size - 1;
        end
        msg_open    = 1'b1;
        fill_offset = 0;
      end
      slot = (head_slot + held_msgs) % ring_size;
      if (fill_offset < MSG_CAP) begin
        slot_bytes[slot][fill_offset] = it.data_byte;
        fill_offset++;
      end
      if (it.last_byte) begin
        slot_len[slot] = LEN_W'(fill_offset);
        held_msgs++;
        msg_open    = 1'b0;
        fill_offset = 0;
      end
    end else if (held_msgs == 0) begin
      r = '{out_byte: 8'h00, msg_length: '0, end_of_message: 1'b1, was_empty: 1'b1};
      step_readout.push_back(r);
    end else begin
      slot = head_slot;
      len  = slot_len[slot];
      for (int k = 0; k < len; k++) begin
        r.out_byte       = slot_bytes[slot][k];
        r.msg_length     = LEN_W'(len);
        r.end_of_message = (k + 1 == len);
        r.was_empty      = 1'b0;
        step_readout.push_back(r);
      end
      head_slot = (head_slot + 1) % ring_size;
      held_msgs--;
    end
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  // sample every transfer, check read-out, mirror commands, watchdog
  always @(posedge clk) begin : sample_edge
    result_t want;
    bit      moved;
    if (rst) begin
      empty_ring(CFG_RESET);
      due_readout.delete();
      stall_cycles = 0;
    end else begin
      moved = 1'b0;
      if (result_valid) begin
        moved = 1'b1;
        if (due_readout.size() == 0) begin
          report_mismatch("read-out with nothing due", readout.out_byte, 0);
        end else begin
          want = due_readout.pop_front();
          if (readout.out_byte !== want.out_byte)
            report_mismatch("out_byte", readout.out_byte, want.out_byte);
          if (readout.msg_length !== want.msg_length)
            report_mismatch("msg_length", readout.msg_length, want.msg_length);
          if (readout.end_of_message !== want.end_of_message)
            report_mismatch("end_of_message", readout.end_of_message,
                            want.end_of_message);
          if (readout.was_empty !== want.was_empty)
            report_mismatch("was_empty", readout.was_empty, want.was_empty);
        end
      end
      if (cfg_valid && cfg_ready) begin
        moved = 1'b1;
        empty_ring(cfg_data);
      end
      if (start && !busy) begin
        moved = 1'b1;
        ring_track(cmd_item);
        if (typed_row) begin
          if (step_readout.size() != 1)
            report_mismatch("read-out count of scripted row", step_readout.size(), 1);
          due_readout.push_back(typed_want);
        end else begin
          foreach (step_readout[i]) due_readout.push_back(step_readout[i]);
        end
      end
      if (moved) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("overwrite_ring_packet_buffer test failed");
        $finish;
      end
    end
  end

  // one command transfer, with an occasional idle burst ahead of it
  task automatic send_item(input item_t it, input bit has_want, input result_t want);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      @(negedge clk) start <= 1'b0;
      repeat ($urandom_range(0, 2)) @(negedge clk);
    end
    @(negedge clk);
    typed_row  = has_want;
    typed_want = want;
    start    <= 1'b1;
    cmd_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
  endtask

  // hold off until every read-out byte has arrived and the block is quiet
  task automatic wait_drained();
    @(negedge clk) start <= 1'b0;
    while (due_readout.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_slots(input logic [CFG_W-1:0] v);
    wait_drained();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  task automatic send_get();
    send_item('{command: CMD_GET, data_byte: 8'($urandom_range(0, 255)),
                last_byte: 1'($urandom_range(0, 1))}, 1'b0, '0);
  endtask

  // stream a message; gets may cut in while it is open
  task automatic put_message(input int unsigned len, input bit close_it);
    item_t it;
    for (int unsigned k = 0; k < len; k++) begin
      if ($urandom_range(0, 14) == 0) send_get();
      it.command   = CMD_PUT;
      it.data_byte = 8'($urandom_range(0, 255));
      it.last_byte = close_it && (k + 1 == len);
      send_item(it, 1'b0, '0);
    end
  endtask

  initial begin : stimulus
    script_row_t       script_rows [$];
    logic [CFG_W-1:0]  phase_slots [9];
    result_t           none_held;
    int unsigned       phase_base;
    int unsigned       get_pct;
    int unsigned       pick;

    none_held   = '{out_byte: 8'h00, msg_length: '0, end_of_message: 1'b1, was_empty: 1'b1};
    phase_slots = '{5'd3, 5'd16, 5'd1, 5'd17, 5'd2, 5'd0, 5'd9, 5'd31, 5'd16};

    // directed script: empty ring, byte extremes, get while open, overwrite
    script_rows.push_back('{ROW_ITEM, '{CMD_GET, 8'h00, 1'b0}, '0, 1'b1, none_held});
    script_rows.push_back('{ROW_ITEM, '{CMD_PUT, 8'h00, 1'b1}, '0, 1'b0, '0});
    script_rows.push_back('{ROW_ITEM, '{CMD_GET, 8'hFF, 1'b1}, '0, 1'b1,
                            '{8'h00, 7'd1, 1'b1, 1'b0}});
    script_rows.push_back('{ROW_ITEM, '{CMD_PUT, 8'hFF, 1'b1}, '0, 1'b0, '0});
    script_rows.push_back('{ROW_ITEM, '{CMD_GET, 8'h00, 1'b0}, '0, 1'b1,
                            '{8'hFF, 7'd1, 1'b1, 1'b0}});
    script_rows.push_back('{ROW_ITEM, '{CMD_PUT, 8'hA5, 1'b0}, '0, 1'b0, '0});
    script_rows.push_back('{ROW_ITEM, '{CMD_GET, 8'h00, 1'b0}, '0, 1'b1, none_held});
    script_rows.push_back('{ROW_ITEM, '{CMD_PUT, 8'h5A, 1'b1}, '0, 1'b0, '0});
    script_rows.push_back('{ROW_ITEM, '{CMD_GET, 8'h00, 1'b0}, '0, 1'b0, '0});
    script_rows.push_back('{ROW_ITEM, '{CMD_PUT, 8'h3C, 1'b1}, '0, 1'b0, '0});
    script_rows.push_back('{ROW_ITEM, '{CMD_PUT, 8'hC3, 1'b0}, '0, 1'b0, '0});
    script_rows.push_back('{ROW_ITEM, '{CMD_PUT, 8'h7E, 1'b1}, '0, 1'b0, '0});
    script_rows.push_back('{ROW_ITEM, '{CMD_GET, 8'h00, 1'b0}, '0, 1'b0, '0});
    script_rows.push_back('{ROW_ITEM, '{CMD_GET, 8'h00, 1'b0}, '0, 1'b0, '0});
    script_rows.push_back('{ROW_ITEM, '{CMD_GET, 8'h00, 1'b0}, '0, 1'b1, none_held});
    // single slot: a second message drops the first
    script_rows.push_back('{ROW_CFG, '0, 5'd1, 1'b0, '0});
    script_rows.push_back('{ROW_ITEM, '{CMD_PUT, 8'h11, 1'b1}, '0, 1'b0, '0});
    script_rows.push_back('{ROW_ITEM, '{CMD_PUT, 8'h22, 1'b1}, '0, 1'b0, '0});
    script_rows.push_back('{ROW_ITEM, '{CMD_GET, 8'h00, 1'b0}, '0, 1'b1,
                            '{8'h22, 7'd1, 1'b1, 1'b0}});
    script_rows.push_back('{ROW_ITEM, '{CMD_GET, 8'h00, 1'b0}, '0, 1'b1, none_held});
    // zero slots acts as one; the open message is dropped by the next write
    script_rows.push_back('{ROW_CFG, '0, 5'd0, 1'b0, '0});
    script_rows.push_back('{ROW_ITEM, '{CMD_PUT, 8'h33, 1'b0}, '0, 1'b0, '0});
    script_rows.push_back('{ROW_ITEM, '{CMD_PUT, 8'h44, 1'b1}, '0, 1'b0, '0});
    script_rows.push_back('{ROW_ITEM, '{CMD_PUT, 8'h55, 1'b0}, '0, 1'b0, '0});
    script_rows.push_back('{ROW_ITEM, '{CMD_GET, 8'h00, 1'b0}, '0, 1'b0, '0});
    script_rows.push_back('{ROW_CFG, '0, 5'd31, 1'b0, '0});
    script_rows.push_back('{ROW_ITEM, '{CMD_GET, 8'h00, 1'b0}, '0, 1'b1, none_held});

    // reset
    repeat (12) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    idle_on = ($urandom_range(0, 1) == 1);
    foreach (script_rows[i]) begin
      if (script_rows[i].kind == ROW_CFG) write_slots(script_rows[i].slots);
      else send_item(script_rows[i].cmd, script_rows[i].typed, script_rows[i].want);
    end

    // random phases, one slot count each
    foreach (phase_slots[p]) begin
      write_slots(phase_slots[p]);
      idle_on    = (p == $size(phase_slots) - 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
      get_pct    = $urandom_range(20, 45);
      phase_base = items_sent;
      // full-length and overlong messages
      if (p == 1) put_message(MSG_CAP, 1'b1);
      if (p == 3) put_message(MSG_CAP + 6, 1'b1);
      while (items_sent - phase_base < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < get_pct) begin
          send_get();
        end else if (pick < get_pct + 8) begin
          // message left without its last byte, so it runs into the next
          put_message($urandom_range(1, 3), 1'b0);
        end else if (pick < get_pct + 11) begin
          wait_drained();
        end else if ($urandom_range(0, 14) == 0) begin
          put_message($urandom_range(MSG_CAP - 4, MSG_CAP + 8), 1'b1);
        end else begin
          put_message($urandom_range(1, 8), 1'b1);
        end
      end
    end

    wait_drained();
    if (fail_count == 0) begin
      $display("overwrite_ring_packet_buffer test passed");
    end else begin
      $display("overwrite_ring_packet_buffer test failed");
    end
    $finish;
  end

endmodule
